// ===== design/cia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_pkg
// Shared constants and control types for the checked integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int CIA_WIDTH = 32;

    // operation codes
    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    // work kinds handed to the back end
    localparam logic [1:0] K_PASS = 2'd0;
    localparam logic [1:0] K_MUL  = 2'd1;
    localparam logic [1:0] K_DIV  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic       neg;
    } t_ctl;

endpackage

// ===== design/cia_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_if
// Request and response channel interfaces for the checked integer ALU.
// ----------------------------------------------------------------------------
interface cia_req_if #(parameter int WIDTH = 32);
    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic signed [WIDTH-1:0] a;
    logic signed [WIDTH-1:0] b;

    modport source (output valid, command, a, b, input ready);
    modport sink   (input valid, command, a, b, output ready);
endinterface

interface cia_rsp_if #(parameter int WIDTH = 32);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] value;
    logic [1:0]              status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

// ===== design/cia_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_front
// Classifies each request: finishes add, subtract and the special cases,
// and prepares operand magnitudes for the shared multiply/divide pipeline.
// ----------------------------------------------------------------------------
module cia_front #(
    parameter int WIDTH = 32
) (
    cia_req_if.sink            i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output cia_pkg::t_ctl      o_ctl,
    output logic [WIDTH-1:0]   o_x,
    output logic [WIDTH-1:0]   o_y
);
    import cia_pkg::*;

    localparam logic [WIDTH-1:0] MIN_INT = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] ALL_ONE = {WIDTH{1'b1}};

    logic [WIDTH-1:0] a, b, sum, dif, ma, mb;
    logic             sa, sb, add_ovf, sub_ovf;

    assign a       = i_req.a;
    assign b       = i_req.b;
    assign sa      = a[WIDTH-1];
    assign sb      = b[WIDTH-1];
    assign sum     = a + b;
    assign dif     = a - b;
    assign add_ovf = (sa == sb) && (sum[WIDTH-1] != sa);
    assign sub_ovf = (sa != sb) && (dif[WIDTH-1] != sa);
    assign ma      = sa ? ({WIDTH{1'b0}} - a) : a;
    assign mb      = sb ? ({WIDTH{1'b0}} - b) : b;

    assign o_valid     = i_req.valid;
    assign i_req.ready = i_ready;

    always_comb begin
        o_ctl.kind   = K_PASS;
        o_ctl.status = ST_OK;
        o_ctl.neg    = sa ^ sb;
        o_x          = '0;
        o_y          = '0;
        case (i_req.command)
            CMD_ADD: begin
                if (add_ovf) begin
                    o_ctl.status = ST_OVF;
                end else begin
                    o_x = sum;
                end
            end
            CMD_SUB: begin
                if (sub_ovf) begin
                    o_ctl.status = ST_OVF;
                end else begin
                    o_x = dif;
                end
            end
            CMD_MUL: begin
                if (a == '0 || b == '0) begin
                    o_x = '0;
                end else if (a == ALL_ONE) begin
                    // negate the other operand
                    if (b == MIN_INT) begin
                        o_ctl.status = ST_OVF;
                    end else begin
                        o_x = {WIDTH{1'b0}} - b;
                    end
                end else if (b == ALL_ONE) begin
                    if (a == MIN_INT) begin
                        o_ctl.status = ST_OVF;
                    end else begin
                        o_x = {WIDTH{1'b0}} - a;
                    end
                end else begin
                    o_ctl.kind = K_MUL;
                    o_x        = mb;
                    o_y        = ma;
                end
            end
            default: begin
                if (b == '0) begin
                    o_ctl.status = ST_DIV0;
                end else if (b == ALL_ONE) begin
                    if (a == MIN_INT) begin
                        o_ctl.status = ST_OVF;
                    end else begin
                        o_x = {WIDTH{1'b0}} - a;
                    end
                end else begin
                    o_ctl.kind = K_DIV;
                    o_x        = ma;
                    o_y        = mb;
                end
            end
        endcase
    end

endmodule

// ===== design/cia_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_queue
// Two-entry queue decoupling the classifier from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module cia_queue #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cia_pkg::t_ctl      i_ctl,
    input  logic [WIDTH-1:0]   i_x,
    input  logic [WIDTH-1:0]   i_y,
    output logic               o_valid,
    input  logic               i_ready,
    output cia_pkg::t_ctl      o_ctl,
    output logic [WIDTH-1:0]   o_x,
    output logic [WIDTH-1:0]   o_y
);
    import cia_pkg::*;

    t_ctl             r_ctl [2];
    logic [WIDTH-1:0] r_x   [2];
    logic [WIDTH-1:0] r_y   [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_count;
    logic             push, pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_ctl   = r_ctl[r_rd];
    assign o_x     = r_x[r_rd];
    assign o_y     = r_y[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ctl[r_wr] <= i_ctl;
            r_x[r_wr]   <= i_x;
            r_y[r_wr]   <= i_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== design/cia_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_back
// Bit-per-stage multiply/divide pipeline with a registered result stage.
// ----------------------------------------------------------------------------
module cia_back #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cia_pkg::t_ctl      i_ctl,
    input  logic [WIDTH-1:0]   i_x,
    input  logic [WIDTH-1:0]   i_y,
    cia_rsp_if.source          o_rsp
);
    import cia_pkg::*;

    localparam logic [WIDTH:0] MAX_INT = {2'b00, {(WIDTH-1){1'b1}}};

    typedef struct packed {
        t_ctl             ctl;
        logic [WIDTH-1:0] x;    // scanned operand, quotient shifts in for divide
        logic [WIDTH-1:0] y;
        logic [WIDTH-1:0] acc;  // product or partial remainder
        logic             ovf;
    } t_stage;

    function automatic t_stage step(input t_stage s);
        logic [WIDTH:0] t;
        logic [WIDTH:0] d;
        logic [WIDTH:0] ty;
        logic           ge;
        t_stage         r;
        r  = s;
        ty = {1'b0, s.y};
        if (s.ctl.kind == K_MUL) begin
            // horner step, sticky flag once the product passes max int
            t     = {s.acc, 1'b0} + (s.x[WIDTH-1] ? ty : {(WIDTH+1){1'b0}});
            r.ovf = s.ovf | (t > MAX_INT);
            r.acc = t[WIDTH-1:0];
            r.x   = {s.x[WIDTH-2:0], 1'b0};
        end else if (s.ctl.kind == K_DIV) begin
            // restoring division step
            t     = {s.acc, s.x[WIDTH-1]};
            d     = t - ty;
            ge    = (t >= ty);
            r.acc = ge ? d[WIDTH-1:0] : t[WIDTH-1:0];
            r.x   = {s.x[WIDTH-2:0], ge};
        end
        return r;
    endfunction

    t_stage                  r_stg [WIDTH+1];
    logic   [WIDTH:0]        r_vld;
    logic                    r_out_valid;
    logic   [WIDTH-1:0]      r_out_value;
    logic   [1:0]            r_out_status;
    logic   [WIDTH-1:0]      n_value;
    logic   [1:0]            n_status;
    logic                    adv;
    t_stage                  last;

    assign adv     = !r_out_valid || o_rsp.ready;
    assign o_ready = adv;
    assign last    = r_stg[WIDTH];

    always_comb begin
        n_value  = last.x;
        n_status = last.ctl.status;
        case (last.ctl.kind)
            K_MUL: begin
                if (last.ovf) begin
                    n_value  = '0;
                    n_status = ST_OVF;
                end else begin
                    n_value  = last.ctl.neg ? ({WIDTH{1'b0}} - last.acc) : last.acc;
                    n_status = ST_OK;
                end
            end
            K_DIV: begin
                // floor: an inexact negative quotient goes one further down
                if (last.ctl.neg) begin
                    n_value = (last.acc != '0) ? ~last.x : ({WIDTH{1'b0}} - last.x);
                end else begin
                    n_value = last.x;
                end
                n_status = ST_OK;
            end
            default: begin
                n_value  = last.x;
                n_status = last.ctl.status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_stg[0].ctl <= i_ctl;
            r_stg[0].x   <= i_x;
            r_stg[0].y   <= i_y;
            r_stg[0].acc <= '0;
            r_stg[0].ovf <= 1'b0;
            for (int k = 0; k < WIDTH; k++) begin
                r_stg[k+1] <= step(r_stg[k]);
            end
            r_out_value  <= n_value;
            r_out_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[WIDTH-1:0], i_valid};
            r_out_valid <= r_vld[WIDTH];
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.value  = r_out_value;
    assign o_rsp.status = r_out_status;

endmodule

// ===== design/checked_integer_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_integer_alu
// Signed add, subtract, multiply and floor divide with overflow checking.
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while the response is not stalled, set by
//   the one-bit-per-stage multiply/divide pipeline that every transaction flows through
// reset: synchronous active-low, empties the queue and the pipeline
// ----------------------------------------------------------------------------
module checked_integer_alu #(
    parameter int WIDTH = cia_pkg::CIA_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cia_req_if.sink    i_req,
    cia_rsp_if.source  o_rsp
);
    import cia_pkg::*;

    // classifier to queue
    logic             f_valid, f_ready;
    t_ctl             f_ctl;
    logic [WIDTH-1:0] f_x, f_y;

    // queue to pipeline
    logic             q_valid, q_ready;
    t_ctl             q_ctl;
    logic [WIDTH-1:0] q_x, q_y;

    // front: add/sub and special cases resolved here, the rest reduced to magnitudes
    cia_front #(.WIDTH(WIDTH)) u_front (
        .i_req   (i_req),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_ctl   (f_ctl),
        .o_x     (f_x),
        .o_y     (f_y)
    );

    // short queue so the classifier keeps taking transactions while the back stalls
    cia_queue #(.WIDTH(WIDTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_ctl   (f_ctl),
        .i_x     (f_x),
        .i_y     (f_y),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_ctl   (q_ctl),
        .o_x     (q_x),
        .o_y     (q_y)
    );

    // back: shared pipeline, resolved transactions ride along to keep order
    cia_back #(.WIDTH(WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_ctl   (q_ctl),
        .i_x     (q_x),
        .i_y     (q_y),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== design/cia_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_checker
// Port-level checks on the response channel of the checked integer ALU.
// ----------------------------------------------------------------------------
module cia_checker #(
    parameter int WIDTH = 32
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic [WIDTH-1:0] i_rsp_value,
    input logic [1:0]       i_rsp_status
);
    import cia_pkg::*;

    // errors always carry a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ST_OK) |-> (i_rsp_value == '0))
        else $error("error status with non-zero value");

    // nothing comes out right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // stalled response stays valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // stalled response keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> ($stable(i_rsp_value) && $stable(i_rsp_status)))
        else $error("response changed while stalled");

endmodule

bind checked_integer_alu cia_checker #(.WIDTH(WIDTH)) u_cia_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_value  (o_rsp.value),
    .i_rsp_status (o_rsp.status)
);
